FILE: rtl/pvsi_pkg.sv
// ----------------------------------------------------------------------------
// pvsi_pkg: shared definitions for the polynomial value/slope/integral block
// Widths, register codes, rounding constants and the reciprocal table for the
// evaluator, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package pvsi_pkg;

	// Highest polynomial order the block supports.
	localparam int MAX_ORDER = 5;

	// Coefficient count and Horner steps (the integral has one extra term).
	localparam int NCOEF = MAX_ORDER + 1;
	localparam int NSTEP = MAX_ORDER + 2;

	// Configuration register map.
	localparam int NREG       = MAX_ORDER + 3;
	localparam int IDX_W      = $clog2(NREG);
	localparam int CFG_W      = 32;
	localparam int ORDER_W    = 3;
	localparam int REG_ORDER  = 0;
	localparam int REG_COEF0  = 1;
	localparam int REG_OFFSET = NCOEF + 1;

	// Datapath widths: x is Q16.16, the accumulator is Q32.16.
	localparam int XW     = 32;
	localparam int ACC_W  = 48;
	localparam int FRAC   = 16;
	localparam int LO_W   = 32;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int PLO_W  = LO_W + XW;
	localparam int PHI_W  = HI_W + XW;
	localparam int PSUM_W = ACC_W + XW;
	localparam int PRD_W  = PSUM_W - FRAC;
	localparam int SUM_W  = PRD_W + 1;

	// Step coefficients: the slope terms grow by up to MAX_ORDER times.
	localparam int KW = CFG_W + $clog2(MAX_ORDER + 1);

	// Integral coefficients: c times round(2^32 / k), scaled back by 2^32.
	localparam int RCP_W    = 32;
	localparam int RCP_FRAC = 32;
	localparam int DP_W     = CFG_W + RCP_W + 1;

	// round(2^32 / k) for k = 2..7; k = 0 and k = 1 never use the table.
	localparam logic [RCP_W-1:0] RECIP_TAB [8] = '{
		32'd0, 32'd0, 32'd2147483648, 32'd1431655765,
		32'd1073741824, 32'd858993459, 32'd715827883, 32'd613566757
	};

	// Round to nearest, ties away from zero: add half, or half less one
	// when the value is negative, then drop the fraction.
	localparam logic [PSUM_W-1:0] RND_POS = PSUM_W'(1) << (FRAC - 1);
	localparam logic [PSUM_W-1:0] RND_NEG = RND_POS - PSUM_W'(1);
	localparam logic [DP_W-1:0]   DP_RND_POS = DP_W'(1) << (RCP_FRAC - 1);
	localparam logic [DP_W-1:0]   DP_RND_NEG = DP_RND_POS - DP_W'(1);

	// Accumulator saturation limits.
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

	// Evaluation lanes.
	localparam int NLANE    = 3;
	localparam int LANE_VAL = 0;
	localparam int LANE_SLP = 1;
	localparam int LANE_INT = 2;

	// Items in flight: input register, three registers per Horner step,
	// then the output register and its skid slot.
	localparam int PIPE_DEPTH = 1 + 3 * NSTEP;
	localparam int CAPACITY   = PIPE_DEPTH + 2;

	// One result.
	typedef struct packed {
		logic signed [ACC_W-1:0] poly_value;
		logic signed [ACC_W-1:0] poly_slope;
		logic signed [ACC_W-1:0] poly_integral;
		logic                    saturated;
	} res_t;

endpackage

FILE: rtl/pvsi_in_if.sv
// ----------------------------------------------------------------------------
// pvsi_in_if: sample channel
// Valid/ready channel that carries one evaluation point per request.
// ----------------------------------------------------------------------------
interface pvsi_in_if import pvsi_pkg::*; ();

	logic                 valid;
	logic                 ready;
	logic signed [XW-1:0] sample_x;

	modport source (output valid, output sample_x, input ready);
	modport sink (input valid, input sample_x, output ready);

endinterface

FILE: rtl/pvsi_out_if.sv
// ----------------------------------------------------------------------------
// pvsi_out_if: result channel
// Valid/ready channel that carries value, slope, integral and the clip flag.
// ----------------------------------------------------------------------------
interface pvsi_out_if import pvsi_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] poly_value;
	logic signed [ACC_W-1:0] poly_slope;
	logic signed [ACC_W-1:0] poly_integral;
	logic                    saturated;

	modport source (
		output valid, output poly_value, output poly_slope,
		output poly_integral, output saturated, input ready
	);
	modport sink (
		input valid, input poly_value, input poly_slope,
		input poly_integral, input saturated, output ready
	);

endinterface

FILE: rtl/polynomial_value_slope_integral.sv
// ----------------------------------------------------------------------------
// polynomial_value_slope_integral: pipelined Horner evaluator
// Evaluates a configured polynomial, its derivative and its integral at one
// Q16.16 point per request, each result saturated to Q32.16.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  -------  ---  ------------  -----------------------------------------------
//  sample   in   valid/ready   sample_x (s32, Q16.16)
//  result   out  valid/ready   poly_value, poly_slope, poly_integral (s48,
//                              Q32.16), saturated
//  cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
//  One request is taken per clock while sample.ready is high. A result passes the
//  input register, three registers per Horner step and then the output register,
//  whatever order is in use. Derived step coefficients follow a register write
//  through kmat_q, the integral terms through dprod_q first; reset clears the
//  configuration registers and all valid bits. A stalled result waits in the
//  output register, one more parks in a skid slot, and sample.ready falls (and
//  the pipeline holds) only while that skid slot is full.
//
module polynomial_value_slope_integral import pvsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	pvsi_in_if.sink          sample,
	pvsi_out_if.source       result
);

	// Configuration registers.
	logic [ORDER_W-1:0]      poly_order_q;
	logic signed [CFG_W-1:0] coef_q [NCOEF];
	logic signed [CFG_W-1:0] offset_q;

	// Derived step coefficients, one row per lane, indexed by power of x.
	logic signed [DP_W-1:0]  dprod_q [1:NCOEF-1];
	logic [DP_W-1:0]         dsum_c [1:NCOEF-1];
	logic signed [CFG_W-1:0] drnd_c [1:NCOEF-1];
	logic [ORDER_W-1:0]      order_eff;
	logic signed [KW-1:0]    kmat_d [NLANE][NSTEP];
	logic signed [KW-1:0]    kmat_q [NLANE][NSTEP];

	// Pipeline registers. Within each Horner step, _s1 holds the partial
	// products, _s2 the rounded product and _s3 the clipped accumulator.
	logic                    vld_s0;
	logic signed [XW-1:0]    x_s0;
	logic                    vld_s1 [NSTEP];
	logic                    vld_s2 [NSTEP];
	logic                    vld_s3 [NSTEP];
	logic                    sat_s1 [NSTEP];
	logic                    sat_s2 [NSTEP];
	logic                    sat_s3 [NSTEP];
	logic signed [XW-1:0]    x_s1 [NSTEP];
	logic signed [XW-1:0]    x_s2 [NSTEP];
	logic signed [XW-1:0]    x_s3 [NSTEP];
	logic signed [PLO_W-1:0] plo_s1 [NSTEP][NLANE];
	logic signed [PHI_W-1:0] phi_s1 [NSTEP][NLANE];
	logic                    neg_s1 [NSTEP][NLANE];
	logic signed [PRD_W-1:0] prd_s2 [NSTEP][NLANE];
	logic signed [ACC_W-1:0] acc_s3 [NSTEP][NLANE];

	// Output register and skid slot.
	res_t out_q;
	res_t skid_q;
	res_t res_c;
	logic out_vld_q;
	logic skid_vld_q;
	logic en;
	logic push;
	logic pop;

	// Register writes; indexes beyond the map are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_order_q <= '0;
			for (int i = 0; i < NCOEF; i++) begin
				coef_q[i] <= '0;
			end
			offset_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == IDX_W'(REG_ORDER)) begin
				poly_order_q <= cfg_data[ORDER_W-1:0];
			end
			for (int i = 0; i < NCOEF; i++) begin
				if (cfg_index == IDX_W'(REG_COEF0 + i)) begin
					coef_q[i] <= $signed(cfg_data);
				end
			end
			if (cfg_index == IDX_W'(REG_OFFSET)) begin
				offset_q <= $signed(cfg_data);
			end
		end
	end

	// First coefficient stage: c_i times the reciprocal of i+1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < NCOEF; i++) begin
				dprod_q[i] <= '0;
			end
		end else begin
			for (int i = 1; i < NCOEF; i++) begin
				dprod_q[i] <= DP_W'(coef_q[i]) * $signed(DP_W'(RECIP_TAB[i + 1]));
			end
		end
	end

	// Second coefficient stage: round the quotients, scale the slope terms
	// and zero every term above the order in use.
	always_comb begin
		order_eff = (poly_order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
			: poly_order_q;
		for (int i = 1; i < NCOEF; i++) begin
			dsum_c[i] = dprod_q[i] + (dprod_q[i][DP_W-1] ? DP_RND_NEG : DP_RND_POS);
			drnd_c[i] = $signed(dsum_c[i][RCP_FRAC+CFG_W-1:RCP_FRAC]);
		end
		for (int n = 0; n < NSTEP; n++) begin
			kmat_d[LANE_VAL][n] = '0;
			kmat_d[LANE_SLP][n] = '0;
			kmat_d[LANE_INT][n] = '0;
			if (n < NCOEF && n <= order_eff) begin
				kmat_d[LANE_VAL][n] = KW'(coef_q[n]);
			end
			if (n < NCOEF - 1 && n < order_eff) begin
				kmat_d[LANE_SLP][n] = KW'(coef_q[n + 1]) * KW'(n + 1);
			end
			if (n == 0) begin
				kmat_d[LANE_INT][n] = KW'(offset_q);
			end else if (n == 1) begin
				kmat_d[LANE_INT][n] = KW'(coef_q[0]);
			end else if (n - 1 <= order_eff) begin
				kmat_d[LANE_INT][n] = KW'(drnd_c[n - 1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NLANE; l++) begin
				for (int n = 0; n < NSTEP; n++) begin
					kmat_q[l][n] <= '0;
				end
			end
		end else begin
			kmat_q <= kmat_d;
		end
	end

	// The pipeline moves as one while the skid slot is free.
	assign en           = !skid_vld_q;
	assign sample.ready = en;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0 <= sample.sample_x;
		end
	end

	// Horner steps, highest power first. Terms above the order are zero,
	// so the accumulator stays zero until the top term in use.
	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		logic signed [ACC_W-1:0] acc_in [NLANE];
		logic signed [XW-1:0]    x_in;
		logic                    vld_in;
		logic                    sat_in;
		logic signed [PLO_W-1:0] plo_c [NLANE];
		logic signed [PHI_W-1:0] phi_c [NLANE];
		logic                    neg_c [NLANE];
		logic [PSUM_W-1:0]       psum_c [NLANE];
		logic signed [SUM_W-1:0] sum_c [NLANE];
		logic signed [ACC_W-1:0] acc_c [NLANE];
		logic [NLANE-1:0]        clip_c;

		// Step input: a zero accumulator for the first step.
		if (j == 0) begin : g_first
			always_comb begin
				x_in   = x_s0;
				vld_in = vld_s0;
				sat_in = 1'b0;
				for (int l = 0; l < NLANE; l++) begin
					acc_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				x_in   = x_s3[j - 1];
				vld_in = vld_s3[j - 1];
				sat_in = sat_s3[j - 1];
				for (int l = 0; l < NLANE; l++) begin
					acc_in[l] = acc_s3[j - 1][l];
				end
			end
		end

		// Multiply: the accumulator is split into a low unsigned word and a
		// high signed word, each multiplied by x.
		always_comb begin
			for (int l = 0; l < NLANE; l++) begin
				plo_c[l] = $signed(PLO_W'(acc_in[l][LO_W-1:0])) * PLO_W'(x_in);
				phi_c[l] = PHI_W'($signed(acc_in[l][ACC_W-1:LO_W])) * PHI_W'(x_in);
				neg_c[l] = (acc_in[l][ACC_W-1] != x_in[XW-1]) && (acc_in[l] != '0)
					&& (x_in != '0);
			end
		end

		// Round: join the partial products and drop the 16 fraction bits.
		always_comb begin
			for (int l = 0; l < NLANE; l++) begin
				psum_c[l] = {phi_s1[j][l], {LO_W{1'b0}}} + PSUM_W'(plo_s1[j][l])
					+ (neg_s1[j][l] ? RND_NEG : RND_POS);
			end
		end

		// Add the step coefficient and clip to the accumulator range.
		always_comb begin
			for (int l = 0; l < NLANE; l++) begin
				sum_c[l]  = SUM_W'(prd_s2[j][l]) + SUM_W'(kmat_q[l][NSTEP-1-j]);
				clip_c[l] = !((&sum_c[l][SUM_W-1:ACC_W-1])
					|| !(|sum_c[l][SUM_W-1:ACC_W-1]));
				if (!clip_c[l]) begin
					acc_c[l] = sum_c[l][ACC_W-1:0];
				end else if (sum_c[l][SUM_W-1]) begin
					acc_c[l] = ACC_MIN;
				end else begin
					acc_c[l] = ACC_MAX;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[j] <= 1'b0;
				vld_s2[j] <= 1'b0;
				vld_s3[j] <= 1'b0;
			end else if (en) begin
				vld_s1[j] <= vld_in;
				vld_s2[j] <= vld_s1[j];
				vld_s3[j] <= vld_s2[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1[j]   <= x_in;
				sat_s1[j] <= sat_in;
				x_s2[j]   <= x_s1[j];
				sat_s2[j] <= sat_s1[j];
				x_s3[j]   <= x_s2[j];
				sat_s3[j] <= sat_s2[j] | (|clip_c);
				for (int l = 0; l < NLANE; l++) begin
					plo_s1[j][l] <= plo_c[l];
					phi_s1[j][l] <= phi_c[l];
					neg_s1[j][l] <= neg_c[l];
					prd_s2[j][l] <= $signed(psum_c[l][PSUM_W-1:FRAC]);
					acc_s3[j][l] <= acc_c[l];
				end
			end
		end
	end

	// Result of the last step.
	always_comb begin
		res_c.poly_value    = acc_s3[NSTEP-1][LANE_VAL];
		res_c.poly_slope    = acc_s3[NSTEP-1][LANE_SLP];
		res_c.poly_integral = acc_s3[NSTEP-1][LANE_INT];
		res_c.saturated     = sat_s3[NSTEP-1];
	end

	assign push = en && vld_s3[NSTEP-1];
	assign pop  = out_vld_q && result.ready;

	// Output register with a skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= res_c;
			end else begin
				out_q <= res_c;
			end
		end
	end

	assign result.valid         = out_vld_q;
	assign result.poly_value    = out_q.poly_value;
	assign result.poly_slope    = out_q.poly_slope;
	assign result.poly_integral = out_q.poly_integral;
	assign result.saturated     = out_q.saturated;

endmodule

FILE: rtl/pvsi_checker.sv
// ----------------------------------------------------------------------------
// pvsi_checker: port-level checks for the polynomial evaluator
// Watches both channels, tracks requests in flight and flags slips in the
// output handshake and in the stall path.
// ----------------------------------------------------------------------------
module pvsi_checker import pvsi_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pvsi_in_if.sink    sample,
	pvsi_out_if.source result
);

	localparam int CNT_W = $clog2(CAPACITY + 1) + 1;

	logic             in_acc;
	logic             out_acc;
	logic [CNT_W-1:0] cnt_q;

	assign in_acc  = sample.valid && sample.ready;
	assign out_acc = result.valid && result.ready;

	// Requests accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result.valid dropped while stalled");

	// A stalled result keeps its payload.
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(result.poly_value)
			&& $stable(result.poly_slope) && $stable(result.poly_integral)
			&& $stable(result.saturated))
		else $error("result payload changed while stalled");

	// Every result answers an earlier request.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q != '0)
		else $error("result delivered with no request in flight");

	// The pipeline never holds more than its stages and output slots.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("more requests in flight than the pipeline holds");

	// Input backpressure only comes from a result parked at the output.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("sample.ready low with an empty output");

endmodule

bind polynomial_value_slope_integral pvsi_checker u_pvsi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);
